[src/gcd_pkg.sv]
// Shared types and constants for the GCD-by-division block.
package gcd_pkg;

    // Width of each operand and result field on the ports.
    localparam int FIELD_W = 32;
    // Default datapath width.
    localparam int WIDTH_DEF = 32;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_OUT
    } t_state;

    // Request to the remainder unit.
    typedef struct packed {
        logic start;
    } t_rem_req;

    // Status from the remainder unit.
    typedef struct packed {
        logic busy;
        logic done;
    } t_rem_sts;

endpackage

[src/gcd_rem.sv]
// Shift-subtract remainder unit, one dividend bit per cycle.
module gcd_rem #(
    parameter int WIDTH = gcd_pkg::WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gcd_pkg::t_rem_req i_req,
    input  logic [WIDTH-1:0]  i_dividend,
    input  logic [WIDTH-1:0]  i_divisor,
    output gcd_pkg::t_rem_sts o_sts,
    output logic [WIDTH-1:0]  o_rem
);

    localparam int CW = $clog2(WIDTH);

    logic [WIDTH-1:0] r_rem, n_rem;
    logic [WIDTH-1:0] r_quo, n_quo;
    logic [WIDTH-1:0] r_den;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [WIDTH:0] trial;
    logic [WIDTH:0] diff;

    // Shift in next dividend bit, subtract divisor when it fits.
    always_comb begin
        trial = {r_rem, r_quo[WIDTH-1]};
        diff  = trial - {1'b0, r_den};
        n_quo = {r_quo[WIDTH-2:0], 1'b0};
        if (diff[WIDTH]) begin
            n_rem = trial[WIDTH-1:0];
        end else begin
            n_rem = diff[WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(WIDTH - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_rem      = r_rem;

endmodule

[src/gcd_by_division.sv]
// Top level: Euclidean GCD sequencer around a single remainder unit, reused for every step.
//
//  channel   dir  handshake                  payload
//  --------  ---  -------------------------  ------------------------------------
//  s (in)    in   i_s_tvalid / o_s_tready    i_s_tdata: operand_a, operand_b
//  m (out)   out  o_m_tvalid / i_m_tready    o_m_tdata: divisor; o_m_tuser: both_zero
//
//  One request at a time. A request is accepted in the idle state; each Euclid
//  step then runs a reload state that starts the remainder unit, its shift-subtract
//  loop over all WIDTH dividend bits and its done pulse. The reload state that
//  sees a zero remainder moves to the output state. Run time grows with the number
//  of remainder steps and is set by the bit-serial remainder loop; a zero operand
//  goes straight from the reload state to the output state.
//  Reset (synchronous, active low) returns the sequencer to idle.
//  A stalled result holds on the master side until taken; the slave side
//  stays not ready until then.
module gcd_by_division #(
    parameter int WIDTH = gcd_pkg::WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // slave side
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [2*gcd_pkg::FIELD_W-1:0] i_s_tdata,  // [31:0] operand_a, [63:32] operand_b
    // master side
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [gcd_pkg::FIELD_W-1:0]   o_m_tdata,  // [31:0] divisor
    output logic                          o_m_tuser   // [0] both_zero
);

    localparam int FW = gcd_pkg::FIELD_W;
    // Common width for the operand fit between port fields and datapath.
    localparam int MW = (WIDTH > FW) ? WIDTH : FW;

    gcd_pkg::t_state r_state, n_state;

    logic [WIDTH-1:0] r_x;       // current larger value
    logic [WIDTH-1:0] r_y;       // current smaller value / divisor
    logic             r_zero;    // both operands were zero

    logic [MW-1:0]    a_ext, b_ext, g_ext;
    logic [WIDTH-1:0] a_w, b_w;
    logic             in_acc;
    logic             y_zero;

    gcd_pkg::t_rem_req rem_req;
    gcd_pkg::t_rem_sts rem_sts;
    logic [WIDTH-1:0]  rem;

    // Fit the port fields to the datapath width (truncate or zero-extend).
    assign a_ext  = MW'(i_s_tdata[FW-1:0]);
    assign b_ext  = MW'(i_s_tdata[2*FW-1:FW]);
    assign a_w    = a_ext[WIDTH-1:0];
    assign b_w    = b_ext[WIDTH-1:0];
    assign in_acc = i_s_tvalid && o_s_tready;
    assign y_zero = (r_y == '0);

    gcd_rem #(
        .WIDTH(WIDTH)
    ) u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (rem_req),
        .i_dividend (r_x),
        .i_divisor  (r_y),
        .o_sts      (rem_sts),
        .o_rem      (rem)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            gcd_pkg::ST_IDLE: begin
                if (i_s_tvalid) n_state = gcd_pkg::ST_LOAD;
            end
            gcd_pkg::ST_LOAD: begin
                // zero divisor ends Euclid; r_x holds the gcd
                if (y_zero) n_state = gcd_pkg::ST_OUT;
                else        n_state = gcd_pkg::ST_DIV;
            end
            gcd_pkg::ST_DIV: begin
                if (rem_sts.done) n_state = gcd_pkg::ST_LOAD;
            end
            gcd_pkg::ST_OUT: begin
                if (i_m_tready) n_state = gcd_pkg::ST_IDLE;
            end
            default: n_state = gcd_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_s_tready    = 1'b0;
        o_m_tvalid    = 1'b0;
        rem_req.start = 1'b0;
        case (r_state)
            gcd_pkg::ST_IDLE: o_s_tready    = 1'b1;
            gcd_pkg::ST_LOAD: rem_req.start = !y_zero;
            gcd_pkg::ST_DIV:  ;
            gcd_pkg::ST_OUT:  o_m_tvalid    = 1'b1;
            default:          ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gcd_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Operand registers: sort on accept, rotate (x, y) <- (y, x mod y) per step.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_x    <= (a_w > b_w) ? a_w : b_w;
            r_y    <= (a_w > b_w) ? b_w : a_w;
            r_zero <= (a_w == '0) && (b_w == '0);
        end else if (r_state == gcd_pkg::ST_DIV && rem_sts.done && !rem_sts.busy) begin
            r_x <= r_y;
            r_y <= rem;
        end
    end

    // Both-zero pair leaves r_x at zero, so the divisor reads 0 there.
    assign g_ext     = MW'(r_x);
    assign o_m_tdata = g_ext[FW-1:0];
    assign o_m_tuser = r_zero;

endmodule

[src/gcd_chk.sv]
// Port-level checker for gcd_by_division, bound to the top level.
module gcd_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_s_tvalid,
    input logic                          o_s_tready,
    input logic [2*gcd_pkg::FIELD_W-1:0] i_s_tdata,
    input logic                          o_m_tvalid,
    input logic                          i_m_tready,
    input logic [gcd_pkg::FIELD_W-1:0]   o_m_tdata,
    input logic                          o_m_tuser
);

    // one request in flight: never ready while a result is shown
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> !o_m_tvalid)
        else $error("ready while result pending");

    // accepted request makes the block busy
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> (!o_s_tready && !o_m_tvalid))
        else $error("not busy after accept");

    // taken result returns the block to idle
    a_idle_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && i_m_tready) |=> (o_s_tready && !o_m_tvalid))
        else $error("not idle after result");

    // both-zero flag carries a zero divisor
    a_zero_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> (o_m_tdata == '0))
        else $error("both_zero with nonzero divisor");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=>
            (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser)))
        else $error("stalled result changed");

endmodule

bind gcd_by_division gcd_chk u_gcd_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
